[hdl/sme_pkg.sv]
// Package for the stack machine execute block: opcodes, error codes, beat types.
// No dependencies.
package sme_pkg;

    localparam logic [4:0] OP_NOP    = 5'd0;
    localparam logic [4:0] OP_PUSH   = 5'd1;
    localparam logic [4:0] OP_POP    = 5'd2;
    localparam logic [4:0] OP_ADD    = 5'd3;
    localparam logic [4:0] OP_DUP    = 5'd4;
    localparam logic [4:0] OP_SUB    = 5'd5;
    localparam logic [4:0] OP_MUL    = 5'd6;
    localparam logic [4:0] OP_DIV    = 5'd7;
    localparam logic [4:0] OP_SWAP   = 5'd8;
    localparam logic [4:0] OP_PRINTC = 5'd9;
    localparam logic [4:0] OP_PRINT  = 5'd10;
    localparam logic [4:0] OP_HALT   = 5'd11;
    localparam logic [4:0] OP_CMPE   = 5'd12;
    localparam logic [4:0] OP_CMPL   = 5'd13;
    localparam logic [4:0] OP_CMPG   = 5'd14;
    localparam logic [4:0] OP_JMPZ   = 5'd15;
    localparam logic [4:0] OP_JMPNZ  = 5'd16;
    localparam logic [4:0] OP_CMPGE  = 5'd17;
    localparam logic [4:0] OP_CMPLE  = 5'd18;
    localparam logic [4:0] OP_JMP    = 5'd19;
    localparam logic [4:0] OP_MOD    = 5'd20;
    localparam logic [4:0] OP_INSWAP = 5'd21;
    localparam logic [4:0] OP_INDUP  = 5'd22;
    localparam logic [4:0] OP_POW    = 5'd24;
    localparam logic [4:0] OP_OR     = 5'd25;
    localparam logic [4:0] OP_XOR    = 5'd26;
    localparam logic [4:0] OP_AND    = 5'd27;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_OVER   = 3'd1;
    localparam logic [2:0] ERR_UNDER  = 3'd2;
    localparam logic [2:0] ERR_DIVZ   = 3'd3;
    localparam logic [2:0] ERR_INDEX  = 3'd4;
    localparam logic [2:0] ERR_OPCODE = 3'd5;

    typedef struct packed {
        logic [4:0]         func;
        logic signed [31:0] operand;
    } in_beat_t;

    typedef struct packed {
        logic               branch_taken;
        logic [15:0]        branch_target;
        logic               print_valid;
        logic               print_is_char;
        logic signed [31:0] print_value;
        logic               halted;
        logic [2:0]         error_code;
        logic [10:0]        stack_depth;
    } out_beat_t;

    // Stack-effect class that the front end attaches to each instruction.
    typedef struct packed {
        logic       valid_op;
        logic [1:0] need;      // entries required below the pointer
        logic       grows;     // pushes one net entry
        logic       binop;     // pops two, pushes one
        logic       indexed;   // checks operand against depth
    } op_class_t;

    typedef struct packed {
        in_beat_t  ins;
        op_class_t cls;
    } queue_entry_t;

endpackage

[hdl/sme_front.sv]
// Front end: accepts instruction beats, classifies them, and queues them.
// Depends on sme_pkg.
module sme_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sme_pkg::in_beat_t     in_data,
    output logic                  q_valid,
    input  logic                  q_pop,
    output sme_pkg::queue_entry_t q_data
);

    localparam int QD = 2;

    sme_pkg::queue_entry_t mem_reg [QD];
    logic                  wr_ptr_reg, rd_ptr_reg;
    logic [1:0]            cnt_reg;
    sme_pkg::op_class_t    cls;
    logic                  push;

    always_comb
    begin
        cls = '0;
        cls.valid_op = 1'b1;
        unique case (in_data.func)
            sme_pkg::OP_NOP, sme_pkg::OP_HALT, sme_pkg::OP_JMP : ;
            sme_pkg::OP_PUSH : cls.grows = 1'b1;
            sme_pkg::OP_POP, sme_pkg::OP_PRINTC, sme_pkg::OP_PRINT,
            sme_pkg::OP_JMPZ, sme_pkg::OP_JMPNZ : cls.need = 2'd1;
            sme_pkg::OP_DUP :
            begin
                cls.need  = 2'd1;
                cls.grows = 1'b1;
            end
            sme_pkg::OP_SWAP : cls.need = 2'd2;
            sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
            sme_pkg::OP_MOD, sme_pkg::OP_POW :
            begin
                cls.need  = 2'd2;
                cls.binop = 1'b1;
            end
            sme_pkg::OP_CMPE, sme_pkg::OP_CMPL, sme_pkg::OP_CMPG, sme_pkg::OP_CMPGE,
            sme_pkg::OP_CMPLE, sme_pkg::OP_OR, sme_pkg::OP_XOR, sme_pkg::OP_AND :
            begin
                cls.need  = 2'd2;
                cls.grows = 1'b1;
            end
            sme_pkg::OP_INSWAP : cls.indexed = 1'b1;
            sme_pkg::OP_INDUP :
            begin
                cls.indexed = 1'b1;
                cls.grows   = 1'b1;
            end
            default : cls.valid_op = 1'b0;
        endcase
    end

    assign in_stall = (cnt_reg == 2'(QD));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{ins: in_data, cls: cls};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QD)) else $error("queue count beyond depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count did not advance");

endmodule

[hdl/sme_divpow.sv]
// Iterative unit: unsigned restoring divide (32 steps) and square-multiply power.
// Depends on sme_pkg only through the caller; standalone logic.
module sme_divpow
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        is_pow,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] quo,
    output logic [31:0] rem
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic        pow_reg;
    logic [31:0] q_reg, r_reg, d_reg;
    logic [32:0] trial;
    logic [31:0] sq, ml;

    assign trial = {r_reg, q_reg[31]} - {1'b0, d_reg};
    // Power: q_reg holds base, r_reg accumulator, d_reg exponent.
    assign sq    = q_reg * q_reg;
    assign ml    = r_reg * q_reg;
    assign done  = busy_reg && (cnt_reg == 6'd0);
    assign quo   = pow_reg ? r_reg : q_reg;
    assign rem   = r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= is_pow ? 6'd31 : 6'd32;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            pow_reg <= is_pow;
            q_reg   <= a;
            r_reg   <= is_pow ? 32'd1 : 32'd0;
            d_reg   <= b;
        end
        else if (busy_reg && cnt_reg != 6'd0)
        begin
            if (pow_reg)
            begin
                if (d_reg[0])
                begin
                    r_reg <= ml;
                end
                q_reg <= sq;
                d_reg <= {1'b0, d_reg[31:1]};
            end
            else if (!trial[32])
            begin
                r_reg <= trial[31:0];
                q_reg <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[30:0], q_reg[31]};
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end

endmodule

[hdl/sme_back.sv]
// Back end: executes queued instructions against the stack memory.
// Depends on sme_pkg and sme_divpow.
module sme_back
#(
    parameter int STACK_DEPTH = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  sme_pkg::queue_entry_t q_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sme_pkg::out_beat_t    out_data
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDT   = 4'd1;
    localparam logic [3:0] S_RDS   = 4'd2;
    localparam logic [3:0] S_RDX   = 4'd3;
    localparam logic [3:0] S_EXEC  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_ITER  = 4'd6;
    localparam logic [3:0] S_WR2   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;
    localparam logic [3:0] S_ADDR  = 4'd9;

    logic [31:0]          mem [STACK_DEPTH];
    logic [31:0]          rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic                 we;
    logic [AW-1:0]        wa;
    logic [31:0]          wd;

    logic [3:0]           state_reg, state_next;
    logic [PW-1:0]        sp_reg;
    logic                 stopped_reg;
    logic [2:0]           err_reg;
    sme_pkg::queue_entry_t cur_reg;
    logic [31:0]          t_reg, s_reg, x_reg, r_reg;
    logic                 taken_reg, pv_reg, pc_reg;
    logic [31:0]          pval_reg;
    logic                 out_valid_reg;
    logic [PW-1:0]        new_sp_reg;
    logic                 two_wr_reg;
    logic [AW-1:0]        wa_reg, wa2_reg;
    logic [31:0]          wd2_reg;

    logic [31:0] ma, mb, mag_s, mag_t;
    logic        dv_start, dv_pow, dv_done;
    logic [31:0] dv_quo, dv_rem;
    logic [31:0] mul_reg;

    logic [4:0]  f;
    logic [31:0] imm;
    logic        lt_ts, lt_st;
    logic        idx_bad;
    logic [2:0]  err_now;

    assign f       = cur_reg.ins.func;
    assign imm     = cur_reg.ins.operand;
    assign lt_ts   = $signed(t_reg) < $signed(s_reg);
    assign lt_st   = $signed(s_reg) < $signed(t_reg);
    assign idx_bad = ({{(32 - PW){1'b0}}, sp_reg} <= imm);
    assign mag_s   = s_reg[31] ? (32'd0 - s_reg) : s_reg;
    assign mag_t   = t_reg[31] ? (32'd0 - t_reg) : t_reg;
    assign ma      = (f == sme_pkg::OP_POW) ? s_reg : mag_s;
    assign mb      = (f == sme_pkg::OP_POW) ? t_reg : mag_t;
    assign dv_pow  = (f == sme_pkg::OP_POW);

    always_comb
    begin
        err_now = sme_pkg::ERR_NONE;
        priority if (!cur_reg.cls.valid_op)
            err_now = sme_pkg::ERR_OPCODE;
        else if (cur_reg.cls.indexed && idx_bad)
            err_now = sme_pkg::ERR_INDEX;
        else if ({{(PW - 2){1'b0}}, cur_reg.cls.need} > sp_reg)
            err_now = sme_pkg::ERR_UNDER;
        else if (cur_reg.cls.grows && sp_reg >= PW'(STACK_DEPTH))
            err_now = sme_pkg::ERR_OVER;
        else if ((f == sme_pkg::OP_DIV || f == sme_pkg::OP_MOD) && t_reg == 32'd0)
            err_now = sme_pkg::ERR_DIVZ;
    end

    sme_divpow u_divpow
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (dv_start),
        .is_pow (dv_pow),
        .a      (ma),
        .b      (mb),
        .done   (dv_done),
        .quo    (dv_quo),
        .rem    (dv_rem)
    );

    // Read address per state: top, second, indexed entry.
    always_comb
    begin
        unique case (state_reg)
            S_RDT   : rd_addr = AW'(sp_reg - PW'(1));
            S_RDS   : rd_addr = AW'(sp_reg - PW'(2));
            default : rd_addr = imm[AW-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    // Take the next instruction only once the previous result beat is gone.
    assign q_pop     = (state_reg == S_IDLE) && q_valid && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = '{branch_taken:  taken_reg,
                         branch_target: taken_reg ? imm[15:0] : 16'd0,
                         print_valid:   pv_reg,
                         print_is_char: pc_reg,
                         print_value:   pval_reg,
                         halted:        stopped_reg,
                         error_code:    err_reg,
                         stack_depth:   11'(sp_reg)};

    always_comb
    begin
        state_next = state_reg;
        dv_start   = 1'b0;
        we         = 1'b0;
        wa         = wa_reg;
        wd         = r_reg;
        unique case (state_reg)
            S_IDLE :
                if (q_pop)
                    state_next = stopped_reg ? S_DONE : S_RDT;
            S_RDT   : state_next = S_RDS;
            S_RDS   : state_next = S_RDX;
            S_RDX   : state_next = S_ADDR;
            S_ADDR  : state_next = S_EXEC;
            S_EXEC  :
            begin
                priority if (err_now != sme_pkg::ERR_NONE)
                    state_next = S_DONE;
                else if (f == sme_pkg::OP_DIV || f == sme_pkg::OP_MOD
                         || f == sme_pkg::OP_POW)
                begin
                    dv_start   = 1'b1;
                    state_next = S_ITER;
                end
                else if (f == sme_pkg::OP_MUL)
                    state_next = S_MUL;
                else
                    state_next = S_WR2;
            end
            S_MUL   : state_next = S_WR2;
            S_ITER  : if (dv_done) state_next = S_WR2;
            S_WR2   :
            begin
                we = two_wr_reg || cur_reg.cls.binop || cur_reg.cls.grows
                     || f == sme_pkg::OP_INSWAP;
                state_next = S_DONE;
            end
            S_DONE  :
            begin
                // Second write of a swap; a stopped machine leaves the stack alone.
                we = two_wr_reg && !stopped_reg;
                wa = wa2_reg;
                wd = wd2_reg;
                state_next = S_IDLE;
            end
            default : state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            stopped_reg   <= 1'b0;
            err_reg       <= sme_pkg::ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == S_EXEC && err_now != sme_pkg::ERR_NONE)
            begin
                stopped_reg <= 1'b1;
                err_reg     <= err_now;
            end
            if (state_reg == S_WR2)
            begin
                sp_reg <= new_sp_reg;
                if (f == sme_pkg::OP_HALT)
                    stopped_reg <= 1'b1;
            end
            if (state_reg == S_DONE)
                out_valid_reg <= 1'b1;
        end
    end

    // Dequeued instruction and operands; results into output registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg   <= q_data;
            taken_reg <= 1'b0;
            pv_reg    <= 1'b0;
            pc_reg    <= 1'b0;
            pval_reg  <= 32'd0;
        end
        if (state_reg == S_RDS)
            t_reg <= (sp_reg >= PW'(1)) ? rd_data_reg : 32'd0;
        if (state_reg == S_RDX)
            s_reg <= (sp_reg >= PW'(2)) ? rd_data_reg : 32'd0;
        if (state_reg == S_ADDR)
            x_reg <= rd_data_reg;
        if (state_reg == S_MUL)
            r_reg <= mul_reg;
        if (state_reg == S_EXEC)
        begin
            mul_reg    <= s_reg * t_reg;
            two_wr_reg <= 1'b0;
            new_sp_reg <= sp_reg;
            wa_reg     <= AW'(sp_reg);
            unique case (f)
                sme_pkg::OP_PUSH :
                begin
                    r_reg <= imm;
                    new_sp_reg <= sp_reg + PW'(1);
                end
                sme_pkg::OP_DUP :
                begin
                    r_reg <= t_reg;
                    new_sp_reg <= sp_reg + PW'(1);
                end
                sme_pkg::OP_INDUP :
                begin
                    r_reg <= x_reg;
                    new_sp_reg <= sp_reg + PW'(1);
                end
                sme_pkg::OP_POP, sme_pkg::OP_JMPZ, sme_pkg::OP_JMPNZ,
                sme_pkg::OP_PRINT, sme_pkg::OP_PRINTC :
                    new_sp_reg <= sp_reg - PW'(1);
                sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
                sme_pkg::OP_MOD, sme_pkg::OP_POW :
                begin
                    r_reg <= (f == sme_pkg::OP_ADD) ? s_reg + t_reg : s_reg - t_reg;
                    new_sp_reg <= sp_reg - PW'(1);
                    wa_reg     <= AW'(sp_reg - PW'(2));
                end
                sme_pkg::OP_SWAP :
                begin
                    r_reg      <= s_reg;
                    wa_reg     <= AW'(sp_reg - PW'(1));
                    two_wr_reg <= 1'b1;
                    wa2_reg    <= AW'(sp_reg - PW'(2));
                    wd2_reg    <= t_reg;
                end
                sme_pkg::OP_INSWAP :
                begin
                    r_reg      <= t_reg;
                    wa_reg     <= imm[AW-1:0];
                    two_wr_reg <= 1'b1;
                    wa2_reg    <= AW'(sp_reg - PW'(1));
                    wd2_reg    <= x_reg;
                end
                sme_pkg::OP_CMPE, sme_pkg::OP_CMPL, sme_pkg::OP_CMPG, sme_pkg::OP_CMPGE,
                sme_pkg::OP_CMPLE, sme_pkg::OP_OR, sme_pkg::OP_XOR, sme_pkg::OP_AND :
                begin
                    new_sp_reg <= sp_reg + PW'(1);
                    unique case (f)
                        sme_pkg::OP_CMPE  : r_reg <= {31'd0, t_reg == s_reg};
                        sme_pkg::OP_CMPL  : r_reg <= {31'd0, lt_ts};
                        sme_pkg::OP_CMPG  : r_reg <= {31'd0, lt_st};
                        sme_pkg::OP_CMPGE : r_reg <= {31'd0, !lt_ts};
                        sme_pkg::OP_CMPLE : r_reg <= {31'd0, !lt_st};
                        sme_pkg::OP_OR    : r_reg <= {31'd0, t_reg != 0 || s_reg != 0};
                        sme_pkg::OP_XOR   : r_reg <= t_reg ^ s_reg;
                        default           : r_reg <= {31'd0, t_reg != 0 && s_reg != 0};
                    endcase
                end
                default : ;
            endcase
            if (err_now == sme_pkg::ERR_NONE)
            begin
                if (f == sme_pkg::OP_JMP)
                    taken_reg <= 1'b1;
                if (f == sme_pkg::OP_JMPZ)
                    taken_reg <= (t_reg == 32'd0);
                if (f == sme_pkg::OP_JMPNZ)
                    taken_reg <= (t_reg != 32'd0);
                if (f == sme_pkg::OP_PRINT || f == sme_pkg::OP_PRINTC)
                begin
                    pv_reg   <= 1'b1;
                    pc_reg   <= (f == sme_pkg::OP_PRINTC);
                    pval_reg <= t_reg;
                end
            end
        end
        if (state_reg == S_ITER && dv_done)
        begin
            priority if (f == sme_pkg::OP_POW)
            begin
                priority if (t_reg == 32'd0)
                    r_reg <= 32'd1;
                else if (t_reg[31])
                    r_reg <= (s_reg == 32'd1) ? 32'd1 :
                             (s_reg == 32'hFFFF_FFFF) ?
                             (t_reg[0] ? 32'hFFFF_FFFF : 32'd1) : 32'd0;
                else
                    r_reg <= dv_quo;
            end
            else if (f == sme_pkg::OP_DIV)
                r_reg <= (s_reg[31] ^ t_reg[31]) ? 32'd0 - dv_quo : dv_quo;
            else
                r_reg <= s_reg[31] ? 32'd0 - dv_rem : dv_rem;
        end
    end

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= PW'(STACK_DEPTH)) else $error("stack pointer beyond depth");
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg) else $error("stopped flag cleared");
    a_err_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != sme_pkg::ERR_NONE) |=> $stable(err_reg))
        else $error("error code changed after stop");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !out_valid_reg) else $error("pop while a result beat waits");

endmodule

[hdl/stack_machine_execute_top.sv]
// Top level of the stack machine execute block.
// Depends on sme_pkg, sme_front, sme_back (and sme_divpow below it).
//
// Usage:
//   in channel  : in_valid / in_stall / in_data (func, operand). A beat is
//                 taken when in_valid is high and in_stall low.
//   out channel : out_valid / out_stall / out_data, one result beat per
//                 instruction, in order.
//   A two-entry queue decouples the classifying front end from the
//   executing back end, so instructions keep arriving while a result
//   waits on a stalled receiver.
//   Each instruction passes three registered stack reads, execute and
//   write-back; mul adds a multiply state, and div, mod and pow wait on
//   the shift-subtract or square-multiply loop of the shared iterative
//   unit. One instruction executes at a time.
//   After a halt or an error later instructions skip straight to done.
//   Reset clears the stack pointer, the stop flag and the error code; the
//   stack memory itself is not cleared. A stalled result holds steady.
module stack_machine_execute_top
#(
    parameter int STACK_DEPTH = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sme_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output sme_pkg::out_beat_t out_data
);

    logic                  q_valid, q_pop;
    sme_pkg::queue_entry_t q_data;

    sme_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_data   (q_data)
    );

    sme_back #(.STACK_DEPTH(STACK_DEPTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

[sim/sme_checker.sv]
// Checker for the stack machine execute block: watches both channels, predicts
// each result beat from the accepted instruction and compares. Depends on sme_pkg.
module sme_checker
#(
    parameter int STACK_DEPTH = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  sme_pkg::in_beat_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  sme_pkg::out_beat_t out_data,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0]        mstack [STACK_DEPTH];
    int unsigned        msp;
    logic               mstopped;
    logic [2:0]         merr;
    sme_pkg::out_beat_t expected_q[$];

    function automatic logic slt(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic logic [31:0] magn(logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    function automatic logic [31:0] int_pow(logic [31:0] base, logic [31:0] ex);
        logic [31:0] acc;
        acc = 32'd1;
        if (ex == 0) return 32'd1;
        if (ex[31])
        begin
            if (base == 32'd1) return 32'd1;
            if (base == 32'hFFFF_FFFF) return ex[0] ? 32'hFFFF_FFFF : 32'd1;
            return 32'd0;
        end
        for (int i = 0; i < 31; i++)
        begin
            if (ex[i]) acc = acc * base;
            base = base * base;
        end
        return acc;
    endfunction

    // Execute one instruction on the shadow stack; return the result beat.
    function automatic sme_pkg::out_beat_t exec_instr(sme_pkg::in_beat_t ins);
        sme_pkg::out_beat_t o;
        int unsigned        sp;
        logic [31:0]        t, s, r, imm;
        logic [2:0]         err;
        logic               halt_now;
        o = '0;
        sp = msp;
        t = 0;
        s = 0;
        r = 0;
        imm = ins.operand;
        err = sme_pkg::ERR_NONE;
        halt_now = 1'b0;
        if (!mstopped)
        begin
            if (sp >= 1) t = mstack[sp-1];
            if (sp >= 2) s = mstack[sp-2];
            case (ins.func)
                sme_pkg::OP_NOP: ;
                sme_pkg::OP_PUSH:
                    if (sp >= STACK_DEPTH) err = sme_pkg::ERR_OVER;
                    else begin mstack[sp] = imm; sp++; end
                sme_pkg::OP_POP:
                    if (sp < 1) err = sme_pkg::ERR_UNDER;
                    else sp--;
                sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
                sme_pkg::OP_MOD, sme_pkg::OP_POW:
                    if (sp < 2) err = sme_pkg::ERR_UNDER;
                    else if ((ins.func == sme_pkg::OP_DIV || ins.func == sme_pkg::OP_MOD)
                             && t == 0)
                        err = sme_pkg::ERR_DIVZ;
                    else
                    begin
                        case (ins.func)
                            sme_pkg::OP_ADD: r = s + t;
                            sme_pkg::OP_SUB: r = s - t;
                            sme_pkg::OP_MUL: r = s * t;
                            sme_pkg::OP_DIV:
                            begin
                                r = magn(s) / magn(t);
                                if (s[31] ^ t[31]) r = -r;
                            end
                            sme_pkg::OP_MOD:
                            begin
                                r = magn(s) % magn(t);
                                if (s[31]) r = -r;
                            end
                            default: r = int_pow(s, t);
                        endcase
                        sp--;
                        mstack[sp-1] = r;
                    end
                sme_pkg::OP_DUP:
                    if (sp < 1) err = sme_pkg::ERR_UNDER;
                    else if (sp >= STACK_DEPTH) err = sme_pkg::ERR_OVER;
                    else begin mstack[sp] = t; sp++; end
                sme_pkg::OP_SWAP:
                    if (sp < 2) err = sme_pkg::ERR_UNDER;
                    else begin mstack[sp-1] = s; mstack[sp-2] = t; end
                sme_pkg::OP_PRINTC, sme_pkg::OP_PRINT:
                    if (sp < 1) err = sme_pkg::ERR_UNDER;
                    else
                    begin
                        sp--;
                        o.print_valid = 1'b1;
                        o.print_is_char = (ins.func == sme_pkg::OP_PRINTC);
                        o.print_value = t;
                    end
                sme_pkg::OP_HALT: halt_now = 1'b1;
                sme_pkg::OP_CMPE, sme_pkg::OP_CMPL, sme_pkg::OP_CMPG, sme_pkg::OP_CMPGE,
                sme_pkg::OP_CMPLE, sme_pkg::OP_OR, sme_pkg::OP_XOR, sme_pkg::OP_AND:
                    if (sp < 2) err = sme_pkg::ERR_UNDER;
                    else if (sp >= STACK_DEPTH) err = sme_pkg::ERR_OVER;
                    else
                    begin
                        case (ins.func)
                            sme_pkg::OP_CMPE:  r = (t == s);
                            sme_pkg::OP_CMPL:  r = slt(t, s);
                            sme_pkg::OP_CMPG:  r = slt(s, t);
                            sme_pkg::OP_CMPGE: r = !slt(t, s);
                            sme_pkg::OP_CMPLE: r = !slt(s, t);
                            sme_pkg::OP_OR:    r = (t != 0 || s != 0);
                            sme_pkg::OP_XOR:   r = t ^ s;
                            default:           r = (t != 0 && s != 0);
                        endcase
                        mstack[sp] = r;
                        sp++;
                    end
                sme_pkg::OP_JMPZ, sme_pkg::OP_JMPNZ:
                    if (sp < 1) err = sme_pkg::ERR_UNDER;
                    else
                    begin
                        sp--;
                        o.branch_taken = ((ins.func == sme_pkg::OP_JMPZ) == (t == 0));
                    end
                sme_pkg::OP_JMP: o.branch_taken = 1'b1;
                sme_pkg::OP_INSWAP:
                    if (imm >= sp) err = sme_pkg::ERR_INDEX;
                    else
                    begin
                        r = mstack[imm];
                        mstack[imm] = t;
                        mstack[sp-1] = r;
                    end
                sme_pkg::OP_INDUP:
                    if (imm >= sp) err = sme_pkg::ERR_INDEX;
                    else if (sp >= STACK_DEPTH) err = sme_pkg::ERR_OVER;
                    else begin mstack[sp] = mstack[imm]; sp++; end
                default: err = sme_pkg::ERR_OPCODE;
            endcase
            if (err != sme_pkg::ERR_NONE)
            begin
                o = '0;
                mstopped = 1'b1;
                merr = err;
            end
            else
            begin
                msp = sp;
                if (halt_now) mstopped = 1'b1;
            end
        end
        if (o.branch_taken) o.branch_target = imm[15:0];
        o.halted = mstopped;
        o.error_code = merr;
        o.stack_depth = msp[10:0];
        return o;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        sme_pkg::out_beat_t exp_beat;
        if (!rst_n)
        begin
            msp <= 0;
            mstopped <= 1'b0;
            merr <= sme_pkg::ERR_NONE;
            fail_count <= 0;
            expected_q.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_q.push_back(exec_instr(in_data));
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result beat with nothing expected: %p", $realtime,
                                 out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_beat = expected_q.pop_front();
                    if (out_data !== exp_beat)
                    begin
                        if (fail_count < 10)
                            $display("%0t: mismatch exp %p got %p", $realtime, exp_beat,
                                     out_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[sim/tb.sv]
// Testbench top for stack_machine_execute_top: clock, reset, instruction
// stimulus with bursty sending and patterned stalls. Depends on sme_pkg, sme_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 1024;
    localparam int CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    sme_pkg::in_beat_t  in_data;
    logic               out_valid;
    logic               out_stall;
    sme_pkg::out_beat_t out_data;
    int                 fail_count;
    int                 pending;
    int                 cycles = 0;

    // Shadow depth so stimulus can steer toward legal programs.
    int        depth_est;

    stack_machine_execute_top #(.STACK_DEPTH(DEPTH)) i_dut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    sme_checker #(.STACK_DEPTH(DEPTH)) i_checker
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: bail out if the block wedges.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver stall pattern: modes cycle between no stall, light and heavy.
    initial
    begin
        int mode;
        int span;
        out_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(5, 60);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Hold one beat until accepted; gaps between beats come from the burst state.
    int burst_left;

    task automatic send_instr(logic [4:0] op, logic [31:0] imm);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= '{func: op, operand: imm};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Reset happens once, so a halted machine simply keeps returning its held state.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    // Track depth changes of a successful instruction (approximate, for steering).
    task automatic track(logic [4:0] op);
        case (op)
            sme_pkg::OP_PUSH, sme_pkg::OP_DUP, sme_pkg::OP_INDUP, sme_pkg::OP_CMPE,
            sme_pkg::OP_CMPL, sme_pkg::OP_CMPG, sme_pkg::OP_CMPGE, sme_pkg::OP_CMPLE,
            sme_pkg::OP_OR, sme_pkg::OP_XOR, sme_pkg::OP_AND: depth_est++;
            sme_pkg::OP_POP, sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL,
            sme_pkg::OP_DIV, sme_pkg::OP_MOD, sme_pkg::OP_POW, sme_pkg::OP_PRINT,
            sme_pkg::OP_PRINTC, sme_pkg::OP_JMPZ, sme_pkg::OP_JMPNZ: depth_est--;
            default: ;
        endcase
    endtask

    logic [4:0] legal_ops [26] = '{sme_pkg::OP_NOP, sme_pkg::OP_PUSH, sme_pkg::OP_POP,
        sme_pkg::OP_ADD, sme_pkg::OP_DUP, sme_pkg::OP_SUB, sme_pkg::OP_MUL,
        sme_pkg::OP_DIV, sme_pkg::OP_SWAP, sme_pkg::OP_PRINTC, sme_pkg::OP_PRINT,
        sme_pkg::OP_CMPE, sme_pkg::OP_CMPL, sme_pkg::OP_CMPG, sme_pkg::OP_JMPZ,
        sme_pkg::OP_JMPNZ, sme_pkg::OP_CMPGE, sme_pkg::OP_CMPLE, sme_pkg::OP_JMP,
        sme_pkg::OP_MOD, sme_pkg::OP_INSWAP, sme_pkg::OP_INDUP, sme_pkg::OP_POW,
        sme_pkg::OP_OR, sme_pkg::OP_XOR, sme_pkg::OP_AND};

    initial
    begin
        logic [4:0]  op;
        logic [31:0] imm;
        int          sent;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        burst_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: div, mod and pow extremes and a selection of other operations.
        send_instr(sme_pkg::OP_PUSH, 32'h8000_0000);
        send_instr(sme_pkg::OP_PUSH, 32'hFFFF_FFFF);
        send_instr(sme_pkg::OP_DIV, 32'd0);            // INT_MIN / -1 wraps
        send_instr(sme_pkg::OP_PUSH, 32'h8000_0000);
        send_instr(sme_pkg::OP_PUSH, 32'hFFFF_FFFF);
        send_instr(sme_pkg::OP_MOD, 32'd0);            // INT_MIN mod -1 is zero
        send_instr(sme_pkg::OP_PUSH, 32'hFFFF_FFF9);
        send_instr(sme_pkg::OP_PUSH, 32'd2);
        send_instr(sme_pkg::OP_MOD, 32'd0);            // remainder keeps dividend sign
        send_instr(sme_pkg::OP_PUSH, 32'd0);
        send_instr(sme_pkg::OP_POW, 32'd0);            // exponent zero gives one
        send_instr(sme_pkg::OP_PUSH, 32'hFFFF_FFFF);
        send_instr(sme_pkg::OP_PUSH, 32'hFFFF_FFFD);
        send_instr(sme_pkg::OP_POW, 32'd0);            // negative exponent, base -1
        send_instr(sme_pkg::OP_INDUP, 32'd0);
        send_instr(sme_pkg::OP_INSWAP, 32'd1);
        send_instr(sme_pkg::OP_OR, 32'd0);
        send_instr(sme_pkg::OP_AND, 32'd0);
        send_instr(sme_pkg::OP_XOR, 32'd0);
        send_instr(sme_pkg::OP_CMPGE, 32'd0);
        send_instr(sme_pkg::OP_JMPNZ, 32'hFFFF_ABCD);
        send_instr(sme_pkg::OP_JMP, 32'h7FFF_1234);
        send_instr(sme_pkg::OP_PRINTC, 32'd0);
        send_instr(sme_pkg::OP_PRINT, 32'd0);
        depth_est = 6;

        // Random: mostly legal programs; occasional errors stop the machine
        // for good, so keep them to the tail of the run.
        sent = 0;
        while (sent < 600)
        begin
            if (sent > 560 && $urandom_range(0, 9) == 0)
                op = 5'($urandom_range(0, 31));   // includes invalid opcodes and halt
            else
                op = legal_ops[$urandom_range(0, 25)];
            imm = rand_word();
            if (op == sme_pkg::OP_INSWAP || op == sme_pkg::OP_INDUP)
                imm = (depth_est > 0 && sent <= 560) ? $urandom_range(0, depth_est - 1)
                                                      : imm;
            if (sent <= 560)
            begin
                // Keep the stack alive and free of divide by zero before the tail.
                if (depth_est < 3 || depth_est > 1000)
                    op = (depth_est < 3) ? sme_pkg::OP_PUSH : sme_pkg::OP_POP;
                if (op == sme_pkg::OP_DIV || op == sme_pkg::OP_MOD)
                begin
                    send_instr(sme_pkg::OP_PUSH,
                               ($urandom_range(0, 1) ? 32'd3 : $urandom) | 32'd1);
                    depth_est++;
                    sent++;
                end
            end
            send_instr(op, imm);
            track(op);
            sent++;
        end
        // Trailing pushes on a stopped or live machine.
        repeat (30) send_instr(sme_pkg::OP_PUSH, $urandom);
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

[files.f]
hdl/sme_pkg.sv
hdl/sme_front.sv
hdl/sme_divpow.sv
hdl/sme_back.sv
hdl/stack_machine_execute_top.sv
sim/sme_checker.sv
sim/tb.sv
